@@ rtl/lobp_pkg.sv @@
// Package for the last-outcome branch predictor.
// Holds field widths, table size default and count limits; no dependencies.
`default_nettype none

package lobp_pkg;

  localparam int unsigned DEFAULT_TABLE_ENTRIES = 64;
  localparam int unsigned ADDR_W                = 32;
  localparam int unsigned CNT_W                 = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Reset value of the default prediction register: taken.
  localparam logic DEFAULT_PRED_RESET = 1'b1;

endpackage : lobp_pkg

`default_nettype wire

@@ rtl/last_outcome_branch_predictor.sv @@
// Top level of the one-bit last-outcome branch predictor.
// Holds the tag table memory, the scan sequencer and the result registers;
// depends on lobp_pkg.
`default_nettype none

// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+---------------------------
// request   | in_branch_addr, in_taken_outcome              | start high, busy low
// result    | out_predicted_taken, out_prediction_correct,  | out_strobe high for one
//           | out_table_hit, out_entry_dropped,             | cycle, no back-pressure
//           | out_correct_count, out_branch_count           |
// config    | cfg_we, cfg_wdata                             | written when cfg_we is high
//
// A request that misses reads each valid table entry in turn through the single
// registered read port of the tag memory, compares the last entry read, and then
// writes the memory, unless the entry is dropped, and registers the result. With an
// empty table it goes straight to the write. A hit ends the scan at the matching entry.
// busy stays high from acceptance until the cycle in which the result is shown,
// so the next request may be taken while the strobe is high.
// rst_n is synchronous and active low; it empties the table by clearing the fill
// level and clears both counts. The receiver cannot stall the result.

module last_outcome_branch_predictor #(
  parameter int unsigned TABLE_ENTRIES = lobp_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Request channel
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [lobp_pkg::ADDR_W-1:0] in_branch_addr,
  input  wire logic                       in_taken_outcome,
  // Result channel
  output logic                            out_strobe,
  output logic                            out_predicted_taken,
  output logic                            out_prediction_correct,
  output logic                            out_table_hit,
  output logic                            out_entry_dropped,
  output logic [lobp_pkg::CNT_W-1:0]      out_correct_count,
  output logic [lobp_pkg::CNT_W-1:0]      out_branch_count,
  // Configuration
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_wdata
);

  // Index width covers the table; the fill level must also hold the full count.
  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned WORD_W = lobp_pkg::ADDR_W + 1;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TABLE_ENTRIES);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  typedef logic [WORD_W-1:0] entry_t;

  // Each memory word packs the tag above the last outcome bit.
  entry_t mem [TABLE_ENTRIES];

  logic [1:0]                   state_r, state_nxt;
  logic [FILL_W-1:0]            fill_r, fill_nxt;
  logic                         dflt_pred_r;
  logic [lobp_pkg::CNT_W-1:0]   correct_r, correct_nxt;
  logic [lobp_pkg::CNT_W-1:0]   total_r, total_nxt;

  // Request held for the duration of the scan.
  logic [lobp_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic                         taken_r, taken_nxt;

  // Scan pipeline: the index being read and the entry whose data is now registered.
  logic [IDX_W-1:0]             scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]             cmp_idx_r, cmp_idx_nxt;
  logic                         cmp_vld_r, cmp_vld_nxt;
  logic                         cmp_last_r, cmp_last_nxt;
  entry_t                       rd_data_r;
  logic                         rd_en;

  // Outcome of the lookup, carried into the write cycle.
  logic                         pred_r, pred_nxt;
  logic                         hit_r, hit_nxt;
  logic                         drop_r, drop_nxt;
  logic                         wr_en_r, wr_en_nxt;
  logic [IDX_W-1:0]             wr_idx_r, wr_idx_nxt;

  // Result registers.
  logic                         out_strobe_r, out_strobe_nxt;
  logic                         out_pred_r, out_corr_r, out_hit_r, out_drop_r;

  logic [FILL_W-1:0]            fill_m1;
  logic [IDX_W-1:0]             last_idx;
  logic                         accept;
  logic                         tag_match;
  logic                         pred_ok;

  assign accept    = start && (state_r == S_IDLE);
  assign fill_m1   = fill_r - FILL_W'(1);
  assign last_idx  = fill_m1[IDX_W-1:0];
  assign tag_match = (rd_data_r[WORD_W-1:1] == addr_r);
  assign pred_ok   = (pred_r == taken_r);
  assign rd_en     = (state_r == S_SCAN);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    correct_nxt    = correct_r;
    total_nxt      = total_r;
    addr_nxt       = addr_r;
    taken_nxt      = taken_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_last_nxt   = cmp_last_r;
    pred_nxt       = pred_r;
    hit_nxt        = hit_r;
    drop_nxt       = drop_r;
    wr_en_nxt      = wr_en_r;
    wr_idx_nxt     = wr_idx_r;
    out_strobe_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          addr_nxt     = in_branch_addr;
          taken_nxt    = in_taken_outcome;
          scan_idx_nxt = '0;
          if (fill_r == '0) begin
            // Empty table: a certain miss, stored in entry zero.
            pred_nxt   = dflt_pred_r;
            hit_nxt    = 1'b0;
            drop_nxt   = 1'b0;
            wr_en_nxt  = 1'b1;
            wr_idx_nxt = '0;
            state_nxt  = S_WRITE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (cmp_vld_r && tag_match) begin
          // Hit: predict the stored outcome and overwrite it in place.
          pred_nxt   = rd_data_r[0];
          hit_nxt    = 1'b1;
          drop_nxt   = 1'b0;
          wr_en_nxt  = 1'b1;
          wr_idx_nxt = cmp_idx_r;
          state_nxt  = S_WRITE;
        end else if (cmp_vld_r && cmp_last_r) begin
          // Miss after the last valid entry: allocate unless the table is full.
          pred_nxt   = dflt_pred_r;
          hit_nxt    = 1'b0;
          drop_nxt   = (fill_r == FILL_FULL);
          wr_en_nxt  = (fill_r != FILL_FULL);
          wr_idx_nxt = fill_r[IDX_W-1:0];
          state_nxt  = S_WRITE;
        end else begin
          // Issue a read of the next entry; its data is compared next cycle.
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_idx_r;
          cmp_last_nxt = (scan_idx_r == last_idx);
          if (scan_idx_r != last_idx) begin
            scan_idx_nxt = scan_idx_r + IDX_W'(1);
          end
        end
      end

      S_WRITE: begin
        if (wr_en_r && !hit_r) begin
          fill_nxt = fill_r + FILL_W'(1);
        end
        if (pred_ok && (correct_r != lobp_pkg::COUNT_MAX)) begin
          correct_nxt = correct_r + lobp_pkg::CNT_W'(1);
        end
        if (total_r != lobp_pkg::COUNT_MAX) begin
          total_nxt = total_r + lobp_pkg::CNT_W'(1);
        end
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      correct_r    <= '0;
      total_r      <= '0;
      dflt_pred_r  <= lobp_pkg::DEFAULT_PRED_RESET;
      cmp_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      correct_r    <= correct_nxt;
      total_r      <= total_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        dflt_pred_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    taken_r    <= taken_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    cmp_last_r <= cmp_last_nxt;
    pred_r     <= pred_nxt;
    hit_r      <= hit_nxt;
    drop_r     <= drop_nxt;
    wr_en_r    <= wr_en_nxt;
    wr_idx_r   <= wr_idx_nxt;
    if (state_r == S_WRITE) begin
      out_pred_r <= pred_r;
      out_corr_r <= pred_ok;
      out_hit_r  <= hit_r;
      out_drop_r <= drop_r;
    end
  end

  // Tag and outcome memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if ((state_r == S_WRITE) && wr_en_r) begin
      mem[wr_idx_r] <= {addr_r, taken_r};
    end
    if (rd_en) begin
      rd_data_r <= mem[scan_idx_r];
    end
  end

  assign busy                   = (state_r != S_IDLE);
  assign out_strobe             = out_strobe_r;
  assign out_predicted_taken    = out_pred_r;
  assign out_prediction_correct = out_corr_r;
  assign out_table_hit          = out_hit_r;
  assign out_entry_dropped      = out_drop_r;
  assign out_correct_count      = correct_r;
  assign out_branch_count       = total_r;

endmodule : last_outcome_branch_predictor

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for the one-bit last-outcome branch predictor.
// Depends on lobp_pkg and last_outcome_branch_predictor; needs nothing else.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Package constants used throughout the bench.
  localparam int unsigned ADDR_W             = lobp_pkg::ADDR_W;
  localparam int unsigned CNT_W              = lobp_pkg::CNT_W;
  localparam logic [CNT_W-1:0] COUNT_MAX     = lobp_pkg::COUNT_MAX;
  localparam logic        DEFAULT_PRED_RESET = lobp_pkg::DEFAULT_PRED_RESET;

  // Table size used for both the block and the local copy of its table.
  localparam int unsigned ENTRIES = lobp_pkg::DEFAULT_TABLE_ENTRIES;

  // The watchdog limit is several times the sum of the time that a full-table
  // request takes and the longest sender gap.
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned TAIL_CYCLES     = ENTRIES + 16;
  localparam int unsigned ITEMS_PER_PHASE = 95;
  localparam int unsigned PHASES          = 5;
  localparam int unsigned SCRIPT_ROWS     = 18;
  localparam int unsigned MAX_REPORTED    = 10;

  // Values of the default prediction register.
  localparam logic PREDICT_TAKEN     = 1'b1;
  localparam logic PREDICT_NOT_TAKEN = 1'b0;

  // One result as the block reports it.
  typedef struct packed {
    logic             predicted;
    logic             correct;
    logic             hit;
    logic             dropped;
    logic [CNT_W-1:0] correct_count;
    logic [CNT_W-1:0] branch_count;
  } verdict_t;

  // One row of the directed script. A row may first set the default
  // prediction, then sends run_len requests at consecutive addresses with the
  // outcome toggling from one to the next. Where typed is set, the result is
  // the one written in the row; otherwise it comes from the local predictor.
  typedef struct {
    bit                set_default;
    logic              default_val;
    logic [ADDR_W-1:0] addr;
    logic              taken;
    int unsigned       run_len;
    bit                typed;
    verdict_t          want;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [ADDR_W-1:0] in_branch_addr = '0;
  logic              in_taken_outcome = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              busy;
  logic              out_strobe;
  logic              out_predicted_taken;
  logic              out_prediction_correct;
  logic              out_table_hit;
  logic              out_entry_dropped;
  logic [CNT_W-1:0]  out_correct_count;
  logic [CNT_W-1:0]  out_branch_count;

  always #5 clk = ~clk;

  last_outcome_branch_predictor #(
    .TABLE_ENTRIES(ENTRIES)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_branch_addr        (in_branch_addr),
    .in_taken_outcome      (in_taken_outcome),
    .out_strobe            (out_strobe),
    .out_predicted_taken   (out_predicted_taken),
    .out_prediction_correct(out_prediction_correct),
    .out_table_hit         (out_table_hit),
    .out_entry_dropped     (out_entry_dropped),
    .out_correct_count     (out_correct_count),
    .out_branch_count      (out_branch_count),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Local predictor: its own copy of the tag table, the fill level, both counts
  // and the default prediction. Only slots below the fill level are looked at.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] shadow_tag  [ENTRIES];
  logic              shadow_last [ENTRIES];
  int unsigned       shadow_fill = 0;
  logic [CNT_W-1:0]  shadow_correct = '0;
  logic [CNT_W-1:0]  shadow_branches = '0;
  logic              shadow_default = DEFAULT_PRED_RESET;

  // Results still owed by the block, oldest first.
  verdict_t pending_verdicts[$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  // Looks the address up, updates the table and the counts, and returns the
  // result that the block must report for this request.
  function automatic verdict_t predict_branch(input logic [ADDR_W-1:0] addr,
                                              input logic taken);
    verdict_t v;
    int       slot;
    int       k;
    v    = '0;
    slot = -1;
    for (k = 0; k < int'(shadow_fill); k++) begin
      if (slot < 0 && shadow_tag[k] == addr) slot = k;
    end
    if (slot >= 0) begin
      v.hit = 1'b1;
      v.predicted = shadow_last[slot];
      shadow_last[slot] = taken;
    end else begin
      v.predicted = shadow_default;
      if (shadow_fill < ENTRIES) begin
        shadow_tag[shadow_fill]  = addr;
        shadow_last[shadow_fill] = taken;
        shadow_fill++;
      end else begin
        // Table full: the new address is simply not stored.
        v.dropped = 1'b1;
      end
    end
    v.correct = (v.predicted == taken);
    // Both counts stop at their ceiling. At a few hundred requests per run the
    // ceiling is far out of reach, but the predictor keeps the rule all the same.
    if (v.correct && shadow_correct != COUNT_MAX) shadow_correct++;
    if (shadow_branches != COUNT_MAX) shadow_branches++;
    v.correct_count = shadow_correct;
    v.branch_count  = shadow_branches;
    return v;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Inputs change only with nonblocking assignments just after a rising
  // edge. start is left high after an acceptance, so that a request sent with no
  // gap keeps it high without being lowered and raised in the same time step.
  // ---------------------------------------------------------------------------
  task automatic issue_request(input logic [ADDR_W-1:0] addr, input logic taken,
                               input bit typed, input verdict_t want);
    verdict_t v;
    start            <= 1'b1;
    in_branch_addr   <= addr;
    in_taken_outcome <= taken;
    // The request is taken at the first edge at which busy is low.
    do @(posedge clk); while (busy);
    v = predict_branch(addr, taken);
    pending_verdicts.push_back(typed ? want : v);
  endtask

  task automatic pause_sender(input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender off until every owed result has come; each request gives
  // exactly one result, so after that the block has no work left.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // The register is only written while the block is idle.
  task automatic write_default(input logic value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    shadow_default = value;
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: each strobe is compared field by field with the oldest
  // owed result. A strobe with nothing owed is a failure as well.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_strobe) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED) $display("result strobe with no request owed");
      end else begin
        want = pending_verdicts.pop_front();
        check_field("predicted_taken", CNT_W'(want.predicted), CNT_W'(out_predicted_taken));
        check_field("prediction_correct", CNT_W'(want.correct),
                    CNT_W'(out_prediction_correct));
        check_field("table_hit", CNT_W'(want.hit), CNT_W'(out_table_hit));
        check_field("entry_dropped", CNT_W'(want.dropped), CNT_W'(out_entry_dropped));
        check_field("correct_count", want.correct_count, out_correct_count);
        check_field("branch_count", want.branch_count, out_branch_count);
      end
    end
  end

  // Watchdog: counts cycles in which neither a request nor a result moves.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("watchdog expired after %0d idle cycles", idle_cycles);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Directed script. The first eleven rows start from an empty table and can be
  // worked out by hand, so their results are written in. The reset default is
  // taken; the fifth and ninth rows switch it and show that hits ignore it. The
  // fill row then brings the table to exactly ENTRIES slots, the next row hits
  // the very last slot, and the rest run on a full table: new addresses are
  // dropped with the default prediction while stored ones still hit.
  // ---------------------------------------------------------------------------
  script_row_t script [SCRIPT_ROWS] = '{
    '{0, PREDICT_TAKEN,     32'h0000_0000, 1'b1, 1, 1, '{1, 1, 0, 0, 32'd1, 32'd1}},
    '{0, PREDICT_TAKEN,     32'hFFFF_FFFF, 1'b0, 1, 1, '{1, 0, 0, 0, 32'd1, 32'd2}},
    '{0, PREDICT_TAKEN,     32'h0000_0000, 1'b0, 1, 1, '{1, 0, 1, 0, 32'd1, 32'd3}},
    '{0, PREDICT_TAKEN,     32'hFFFF_FFFF, 1'b0, 1, 1, '{0, 1, 1, 0, 32'd2, 32'd4}},
    '{1, PREDICT_NOT_TAKEN, 32'h8000_0000, 1'b0, 1, 1, '{0, 1, 0, 0, 32'd3, 32'd5}},
    '{0, PREDICT_NOT_TAKEN, 32'h7FFF_FFFF, 1'b1, 1, 1, '{0, 0, 0, 0, 32'd3, 32'd6}},
    '{0, PREDICT_NOT_TAKEN, 32'h7FFF_FFFF, 1'b1, 1, 1, '{1, 1, 1, 0, 32'd4, 32'd7}},
    '{0, PREDICT_NOT_TAKEN, 32'h8000_0000, 1'b1, 1, 1, '{0, 0, 1, 0, 32'd4, 32'd8}},
    '{1, PREDICT_TAKEN,     32'h0000_0000, 1'b1, 1, 1, '{0, 0, 1, 0, 32'd4, 32'd9}},
    '{0, PREDICT_TAKEN,     32'hAAAA_AAAA, 1'b1, 1, 1, '{1, 1, 0, 0, 32'd5, 32'd10}},
    '{0, PREDICT_TAKEN,     32'h5555_5555, 1'b0, 1, 1, '{1, 0, 0, 0, 32'd5, 32'd11}},
    '{0, PREDICT_TAKEN,     32'h1000_0000, 1'b0, ENTRIES - 6, 0, '0},
    '{0, PREDICT_TAKEN,     32'h1000_0000 + ENTRIES - 7, 1'b1, 1, 0, '0},
    '{0, PREDICT_TAKEN,     32'hDEAD_BEEF, 1'b1, 1, 0, '0},
    '{0, PREDICT_TAKEN,     32'hDEAD_BEEF, 1'b0, 1, 0, '0},
    '{1, PREDICT_NOT_TAKEN, 32'h1234_5678, 1'b0, 1, 0, '0},
    '{0, PREDICT_NOT_TAKEN, 32'h0000_0000, 1'b0, 1, 0, '0},
    '{1, PREDICT_TAKEN,     32'hFFFF_FFFF, 1'b1, 1, 0, '0}
  };

  // A few addresses that are sent again and again but are never in the table
  // once it is full, so that dropped requests repeat.
  logic [ADDR_W-1:0] outsider [8];

  initial begin : stimulus
    logic [ADDR_W-1:0] addr;
    logic              taken;
    int unsigned       r;
    bit                burst;
    int unsigned       row;
    int unsigned       k;
    int unsigned       phase;
    int unsigned       n;

    foreach (outsider[i]) outsider[i] = $urandom;

    // Reset once, with every input at a known value.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < SCRIPT_ROWS; row++) begin
      if (script[row].set_default) write_default(script[row].default_val);
      for (k = 0; k < script[row].run_len; k++) begin
        issue_request(script[row].addr + k, script[row].taken ^ k[0],
                      script[row].typed, script[row].want);
        pause_sender(pick_gap());
      end
    end

    // Random part. Most requests reuse addresses already in the table, so that
    // hits fall on every slot and the scan length varies; the rest are repeat
    // outsiders and fresh random addresses, which are dropped. Each address has
    // a preferred direction taken from one of its bits, broken now and then, so
    // that correct and wrong predictions both occur. Every phase starts with an
    // idle write of the default; odd phases send back to back with no gaps.
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) write_default(PREDICT_NOT_TAKEN);
      else if (phase == 1) write_default(PREDICT_TAKEN);
      else write_default(logic'($urandom_range(0, 1)));
      burst = phase[0];
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 70 && shadow_fill > 0) addr = shadow_tag[$urandom_range(0, shadow_fill - 1)];
        else if (r < 85) addr = outsider[$urandom_range(0, 7)];
        else addr = $urandom;
        taken = ($urandom_range(0, 3) == 0) ? ~addr[2] : addr[2];
        issue_request(addr, taken, 1'b0, '0);
        if (!burst) pause_sender(pick_gap());
      end
    end

    // Let every owed result arrive, then give the block time to show any
    // stray strobe before the verdict.
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : tb

`default_nettype wire
